>>> src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge, skipped while reset is asserted.
`define ASSERT_CLKRST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Checked on every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_CLKRST(label, clk, rst_n, prop)
`define ASSERT_CLK(label, clk, prop)

`endif

`endif

>>> src/rhfs_pkg.sv
package rhfs_pkg;

    // Default queue depth (entries per queue)
    localparam int QUEUE_DEPTH_DEF = 128;

    localparam int ADDR_W  = 32;
    localparam int STAMP_W = 32;

    // Transaction function codes
    localparam logic FUNC_ENQUEUE  = 1'b0;
    localparam logic FUNC_SCHEDULE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_GRANTED  = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic               func;
        logic [ADDR_W-1:0]  address;
        logic [STAMP_W-1:0] stamp;
        logic               row_hit;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [ADDR_W-1:0]  granted_address;
        logic [STAMP_W-1:0] granted_stamp;
        logic               granted_hit;
    } t_rsp;

    // One stored request
    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    // Queue occupancy flags seen by the scheduler
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

>>> src/row_hit_first_request_scheduler.sv
// Channel   Handshake            Payload
// request   start / busy         i_req  (func, address, stamp, row_hit)
// result    o_done (one cycle)   o_rsp  (status, granted_address, granted_stamp, granted_hit)
//
// One transaction per cycle; busy stays low. The result appears in the cycle after
// the transaction is taken, for exactly one cycle; the granted entry comes from the
// queue memory's registered read port. Synchronous active-low reset empties both queues
// (stored entries are not cleared). The receiver cannot stall the result.
`include "assert_macros.svh"

module row_hit_first_request_scheduler #(
    parameter int QUEUE_DEPTH = rhfs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  rhfs_pkg::t_req i_req,
    output logic           o_done,
    output rhfs_pkg::t_rsp o_rsp
);

    rhfs_pkg::t_queue_status w_hit_st, w_miss_st;
    rhfs_pkg::t_entry        w_hit_rdata, w_miss_rdata, w_entry, w_gnt;

    logic w_enq, w_sched;
    logic w_push_hit, w_push_miss, w_pop_hit, w_pop_miss;

    logic       r_done;
    logic [1:0] r_status, n_status;
    logic       r_from_hit;

    assign busy = 1'b0;

    // Decode the transaction
    assign w_enq   = start && (i_req.func == rhfs_pkg::FUNC_ENQUEUE);
    assign w_sched = start && (i_req.func == rhfs_pkg::FUNC_SCHEDULE);

    assign w_entry.address = i_req.address;
    assign w_entry.stamp   = i_req.stamp;

    // Push to the selected queue unless it is full
    assign w_push_hit  = w_enq &&  i_req.row_hit && !w_hit_st.full;
    assign w_push_miss = w_enq && !i_req.row_hit && !w_miss_st.full;

    // Row hits first, then the oldest miss
    assign w_pop_hit  = w_sched && !w_hit_st.empty;
    assign w_pop_miss = w_sched &&  w_hit_st.empty && !w_miss_st.empty;

    always_comb begin
        n_status = rhfs_pkg::ST_ENQUEUED;
        if (w_enq) begin
            n_status = (w_push_hit || w_push_miss) ? rhfs_pkg::ST_ENQUEUED
                                                   : rhfs_pkg::ST_DROPPED;
        end else if (w_pop_hit || w_pop_miss) begin
            n_status = rhfs_pkg::ST_GRANTED;
        end else begin
            n_status = rhfs_pkg::ST_EMPTY;
        end
    end

    rhfs_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_hit_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push_hit),
        .i_pop    (w_pop_hit),
        .i_data   (w_entry),
        .o_status (w_hit_st),
        .o_rdata  (w_hit_rdata)
    );

    rhfs_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_miss_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push_miss),
        .i_pop    (w_pop_miss),
        .i_data   (w_entry),
        .o_status (w_miss_st),
        .o_rdata  (w_miss_rdata)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_status   <= n_status;
            r_from_hit <= w_pop_hit;
        end
    end

    // Granted fields read zero unless a request was granted
    assign w_gnt = r_from_hit ? w_hit_rdata : w_miss_rdata;

    assign o_done                = r_done;
    assign o_rsp.status          = r_status;
    assign o_rsp.granted_address = (r_status == rhfs_pkg::ST_GRANTED) ? w_gnt.address : '0;
    assign o_rsp.granted_stamp   = (r_status == rhfs_pkg::ST_GRANTED) ? w_gnt.stamp : '0;
    assign o_rsp.granted_hit     = (r_status == rhfs_pkg::ST_GRANTED) && r_from_hit;

    // Each transaction yields exactly one result in the next cycle
    `ASSERT_CLKRST(a_one_result, i_clk, i_rst_n, start |=> o_done)
    `ASSERT_CLKRST(a_no_spurious, i_clk, i_rst_n, !start |=> !o_done)
    // Never pop both queues at once
    `ASSERT_CLK(a_single_pop, i_clk, !(w_pop_hit && w_pop_miss))
    // A granted schedule took from the hit queue whenever it held anything
    `ASSERT_CLKRST(a_hit_first, i_clk, i_rst_n,
        (w_sched && !w_hit_st.empty) |=> (o_rsp.granted_hit && o_done))

endmodule

>>> src/rhfs_queue.sv
`include "assert_macros.svh"

module rhfs_queue #(
    parameter int QUEUE_DEPTH = rhfs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic                   i_pop,
    input  rhfs_pkg::t_entry       i_data,
    output rhfs_pkg::t_queue_status o_status,
    output rhfs_pkg::t_entry       o_rdata
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    rhfs_pkg::t_entry r_mem [QUEUE_DEPTH];
    rhfs_pkg::t_entry r_rdata;

    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;

    // Storage: write at tail, registered read at head
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_data;
        end
        if (i_pop) begin
            r_rdata <= r_mem[r_head];
        end
    end

    // Pointer and occupancy update, wrapping at the last entry
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_push) begin
            n_tail = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + PTR_W'(1);
        end
        if (i_pop) begin
            n_head = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_rdata        = r_rdata;

    // Occupancy never exceeds the depth
    `ASSERT_CLKRST(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(QUEUE_DEPTH))
    // A pop only ever hits a non-empty queue, a push a non-full one
    `ASSERT_CLKRST(a_no_underflow, i_clk, i_rst_n, i_pop |-> !o_status.empty)
    `ASSERT_CLKRST(a_no_overflow, i_clk, i_rst_n, i_push |-> !o_status.full)
    // Count follows a lone push
    `ASSERT_CLKRST(a_count_push, i_clk, i_rst_n,
        (i_push && !i_pop) |=> r_count == $past(r_count) + CNT_W'(1))

endmodule

>>> tb/sv/row_hit_first_request_scheduler_tb.sv
module row_hit_first_request_scheduler_tb;
    import rhfs_pkg::*;

    localparam int DEPTH        = QUEUE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 700;
    localparam int MAX_REPORTS  = 10;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_done;
    t_rsp o_rsp;

    row_hit_first_request_scheduler #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    // Requests waiting to be driven, responses waiting to come back
    t_req request_queue[$];
    t_rsp awaited_rsps[$];

    int   total_items;
    int   accepted_cnt;
    int   error_cnt;
    logic req_taken;

    // Shadow of both queues: index 0 is the miss queue, 1 the hit queue
    t_entry shadow_store[2][DEPTH];
    int     shadow_head[2];
    int     shadow_tail[2];
    int     shadow_fill[2];

    // Occupancy tracked while building the stimulus, to aim fill and drain bursts
    int gen_fill[2];

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one transaction to the shadow queues and return its response
    function automatic t_rsp resolve_request(t_req r);
        t_rsp rsp;
        int   q;
        rsp = '0;
        if (r.func == FUNC_ENQUEUE) begin
            q = r.row_hit ? 1 : 0;
            if (shadow_fill[q] >= DEPTH) begin
                rsp.status = ST_DROPPED;
            end else begin
                shadow_store[q][shadow_tail[q]] = '{r.address, r.stamp};
                shadow_tail[q] = (shadow_tail[q] + 1) % DEPTH;
                shadow_fill[q]++;
                rsp.status = ST_ENQUEUED;
            end
        end else begin
            // Row hits always win over misses
            q = (shadow_fill[1] != 0) ? 1 : 0;
            if (shadow_fill[q] == 0) begin
                rsp.status = ST_EMPTY;
            end else begin
                rsp.status          = ST_GRANTED;
                rsp.granted_address = shadow_store[q][shadow_head[q]].address;
                rsp.granted_stamp   = shadow_store[q][shadow_head[q]].stamp;
                rsp.granted_hit     = (q == 1);
                shadow_head[q] = (shadow_head[q] + 1) % DEPTH;
                shadow_fill[q]--;
            end
        end
        return rsp;
    endfunction

    task automatic flag_error(string msg);
        if (error_cnt < MAX_REPORTS) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        error_cnt++;
    endtask

    // Queue one request for the driver, tracking occupancy for burst shaping
    task automatic add_request(logic func, logic [31:0] addr, logic [31:0] stamp, logic hit);
        request_queue.push_back('{func, addr, stamp, hit});
        if (func == FUNC_ENQUEUE) begin
            if (gen_fill[hit] < DEPTH) gen_fill[hit]++;
        end else if (gen_fill[1] > 0) begin
            gen_fill[1]--;
        end else if (gen_fill[0] > 0) begin
            gen_fill[0]--;
        end
    endtask

    task automatic add_random_enqueue(logic hit);
        add_request(FUNC_ENQUEUE, $urandom, $urandom, hit);
    endtask

    // Schedule with junk in the unused fields
    task automatic add_random_schedule();
        add_request(FUNC_SCHEDULE, $urandom, $urandom, 1'($urandom_range(0, 1)));
    endtask

    // Driver: new values on the falling edge
    always @(negedge i_clk) begin : request_driver
        int          idle_pct;
        logic [95:0] junk;
        junk = {$urandom, $urandom, $urandom};
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (req_taken) void'(request_queue.pop_front());
            case ((accepted_cnt * 3) / total_items)
                0:       idle_pct = 8;
                1:       idle_pct = 55;
                default: idle_pct = 0;
            endcase
            if (request_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                start <= 1'b1;
                i_req <= request_queue[0];
            end else begin
                start <= 1'b0;
                i_req <= junk[$bits(t_req)-1:0];
            end
        end
    end

    // Monitor: check responses and record accepted requests on the rising edge
    always @(posedge i_clk) begin : response_check
        t_rsp want;
        req_taken <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (o_done) begin
                if (awaited_rsps.size() == 0) begin
                    flag_error($sformatf("unexpected response %h", o_rsp));
                end else begin
                    want = awaited_rsps.pop_front();
                    if (o_rsp.status !== want.status
                            || o_rsp.granted_address !== want.granted_address
                            || o_rsp.granted_stamp !== want.granted_stamp
                            || o_rsp.granted_hit !== want.granted_hit) begin
                        flag_error($sformatf(
                            "exp status %0d addr %h stamp %h hit %b, got %0d %h %h %b",
                            want.status, want.granted_address, want.granted_stamp,
                            want.granted_hit, o_rsp.status, o_rsp.granted_address,
                            o_rsp.granted_stamp, o_rsp.granted_hit));
                    end
                end
            end
            if (start && !busy) begin
                awaited_rsps.push_back(resolve_request(i_req));
                accepted_cnt++;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        int random_cnt;
        int burst;
        int kind;
        int q;
        int n;
        int guard;

        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req        = '0;
        req_taken    = 1'b0;
        accepted_cnt = 0;
        error_cnt    = 0;
        random_cnt   = 0;
        for (int i = 0; i < 2; i++) begin
            shadow_head[i] = 0;
            shadow_tail[i] = 0;
            shadow_fill[i] = 0;
            gen_fill[i]    = 0;
        end

        // Directed: empty schedules, field extremes, hit priority
        add_request(FUNC_SCHEDULE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        add_request(FUNC_SCHEDULE, 32'h0, 32'h0, 1'b0);
        add_request(FUNC_ENQUEUE, 32'h0, 32'h0, 1'b0);
        add_request(FUNC_ENQUEUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_request(FUNC_ENQUEUE, 32'hFFFF_FFFF, 32'h0, 1'b1);
        add_request(FUNC_ENQUEUE, 32'h0, 32'hFFFF_FFFF, 1'b1);
        add_request(FUNC_ENQUEUE, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0);
        add_request(FUNC_SCHEDULE, 32'hFFFF_FFFF, 32'h0, 1'b0);
        add_request(FUNC_SCHEDULE, 32'h0, 32'hFFFF_FFFF, 1'b1);
        add_request(FUNC_SCHEDULE, 32'h1234_5678, 32'h8765_4321, 1'b1);
        add_request(FUNC_ENQUEUE, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b1);
        add_request(FUNC_SCHEDULE, 32'h0, 32'h0, 1'b0);
        add_request(FUNC_SCHEDULE, 32'h0, 32'h0, 1'b0);
        add_request(FUNC_SCHEDULE, 32'h0, 32'h0, 1'b0);
        add_request(FUNC_SCHEDULE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);

        // Random bursts: fill to overflow, drain past empty, or mixed traffic
        for (burst = 0; random_cnt < RANDOM_ITEMS; burst++) begin
            kind = (burst == 0) ? 0 : $urandom_range(0, 11);
            if (kind == 0) begin
                q = $urandom_range(0, 1);
                n = DEPTH - gen_fill[q] + $urandom_range(1, 3);
                repeat (n) add_random_enqueue(q[0]);
            end else if (kind <= 4) begin
                n = $urandom_range(1, gen_fill[0] + gen_fill[1] + 2);
                repeat (n) add_random_schedule();
            end else begin
                n = $urandom_range(1, 24);
                repeat (n) begin
                    if ($urandom_range(0, 99) < 55) begin
                        add_random_enqueue(1'($urandom_range(0, 1)));
                    end else begin
                        add_random_schedule();
                    end
                end
            end
            random_cnt += n;
        end
        total_items = request_queue.size();

        // Hold reset, then release it on a falling edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for all transactions, then for the last responses
        wait (accepted_cnt == total_items);
        guard = 0;
        while (awaited_rsps.size() != 0 && guard < 100) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (5) @(posedge i_clk);
        if (awaited_rsps.size() != 0) begin
            flag_error($sformatf("%0d responses never arrived", awaited_rsps.size()));
        end

        if (error_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
